// File: hdl/ffl_alloc_pkg.sv
package ffl_alloc_pkg;

	localparam int SLOTS_DEFAULT = 256;
	localparam int SLOT_W = 9;
	localparam int TAG_W = 32;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_IN_USE = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_OWNER = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// File: hdl/ffl_alloc_ram.sv
module ffl_alloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/fifo_free_list_id_allocator_top.sv
// Slot allocator with first-in first-out reuse of released slots.
//
// A request is taken at a rising edge where start is high and busy is low.
// kind 0 allocates the oldest free slot and stores owner_tag with it; kind 1
// releases slot_number, which must be in range, in use and owned by owner_tag.
// Every request gives exactly one result: done is high for one cycle with
// granted_slot and status on the result ports. The receiver cannot stall, so
// a result is never held back.
//
// Order of events: an accepted request moves the block to ST_EXEC, where the
// result is decided and registered for the strobe; the block does not take
// the next request until it is back in ST_IDLE. The free queue, the owner table
// and the in-use flags are single-port-read memories: the accept cycle issues the
// reads and the following cycle decides the result and writes the memories back.
//
// After reset the block runs a clearing pass over the in-use flags, one entry a
// cycle, up to the last entry; busy stays high for that time. The free queue needs
// no clearing: positions not yet written read back as their own index.
module fifo_free_list_id_allocator_top #(
	parameter int SLOTS = ffl_alloc_pkg::SLOTS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  kind,
	input  logic [ffl_alloc_pkg::SLOT_W-1:0]      slot_number,
	input  logic [ffl_alloc_pkg::TAG_W-1:0]       owner_tag,
	output logic                                  done,
	output logic [ffl_alloc_pkg::SLOT_W-1:0]      granted_slot,
	output logic [ffl_alloc_pkg::STATUS_W-1:0]    status
);

	import ffl_alloc_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	state_t state_q, state_d;

	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic             wrapped_q, wrapped_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] clr_q;

	logic              kind_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              range_bad_s1;
	logic [TAG_W-1:0]  tag_s1;

	logic                done_q;
	logic [SLOT_W-1:0]   granted_q, granted_d;
	logic [STATUS_W-1:0] status_q, status_d;

	logic             accept;
	logic [IDX_W-1:0] rel_idx;
	logic             range_bad;

	logic             q_we;
	logic [IDX_W-1:0] q_waddr;
	logic [IDX_W-1:0] q_wdata;
	logic [IDX_W-1:0] q_rdata;
	logic [IDX_W-1:0] q_slot;

	logic             use_we;
	logic [IDX_W-1:0] use_waddr;
	logic             use_wdata;
	logic             use_rdata;

	logic             own_we;
	logic [TAG_W-1:0] own_rdata;

	assign accept = start && (state_q == ST_IDLE);
	assign rel_idx = IDX_W'(32'(slot_number) - 32'd1);
	assign range_bad = (slot_number == '0) || (32'(slot_number) > 32'(SLOTS));

	// A queue position that the tail has not yet reached is taken as its own index.
	assign q_slot = (wrapped_q || (head_q < tail_q)) ? q_rdata : head_q;

	ffl_alloc_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (accept),
		.raddr (head_q),
		.rdata (q_rdata)
	);

	ffl_alloc_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_in_use_ram (
		.clk   (clk),
		.we    (use_we),
		.waddr (use_waddr),
		.wdata (use_wdata),
		.re    (accept),
		.raddr (rel_idx),
		.rdata (use_rdata)
	);

	ffl_alloc_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (q_slot),
		.wdata (tag_s1),
		.re    (accept),
		.raddr (rel_idx),
		.rdata (own_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		q_we = 1'b0;
		q_waddr = tail_q;
		q_wdata = idx_s1;
		use_we = 1'b0;
		use_waddr = clr_q;
		use_wdata = 1'b0;
		own_we = 1'b0;
		head_d = head_q;
		tail_d = tail_q;
		wrapped_d = wrapped_q;
		count_d = count_q;
		granted_d = '0;
		status_d = STATUS_OK;
		case (state_q)
			ST_CLEAR: begin
				use_we = 1'b1;
			end
			ST_EXEC: begin
				if (!kind_s1) begin
					if (count_q == '0) begin
						status_d = STATUS_EXHAUSTED;
					end else begin
						use_we = 1'b1;
						use_waddr = q_slot;
						use_wdata = 1'b1;
						own_we = 1'b1;
						head_d = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
						count_d = count_q - CNT_W'(1);
						granted_d = SLOT_W'(32'(q_slot) + 32'd1);
					end
				end else begin
					if (range_bad_s1) begin
						status_d = STATUS_RANGE;
					end else if (!use_rdata) begin
						status_d = STATUS_NOT_IN_USE;
					end else if (own_rdata != tag_s1) begin
						status_d = STATUS_OWNER;
					end else begin
						use_we = 1'b1;
						use_waddr = idx_s1;
						use_wdata = 1'b0;
						q_we = 1'b1;
						if (tail_q == LAST_IDX) begin
							tail_d = '0;
							wrapped_d = 1'b1;
						end else begin
							tail_d = tail_q + IDX_W'(1);
						end
						count_d = count_q + CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			head_q <= '0;
			tail_q <= '0;
			wrapped_q <= 1'b0;
			count_q <= CNT_W'(SLOTS);
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			wrapped_q <= wrapped_d;
			count_q <= count_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			done_q <= (state_q == ST_EXEC);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			idx_s1 <= rel_idx;
			range_bad_s1 <= range_bad;
			tag_s1 <= owner_tag;
		end
		if (state_q == ST_EXEC) begin
			granted_q <= granted_d;
			status_q <= status_d;
		end
	end

	assign done = done_q;
	assign granted_slot = granted_q;
	assign status = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC) && busy)
		else $error("Accepted request did not enter execution.");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("Result strobe without an executed request.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (granted_slot != '0)) |-> (status == STATUS_OK))
		else $error("Slot granted with a failing status.");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(SLOTS))
		else $error("Free count exceeds the pool size.");

endmodule
